// ===== src/postfix_expression_evaluator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the postfix evaluator
// ---------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// implication checked on every edge outside reset
`define PEE_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define PEE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/pee_pkg.sv =====
// ---------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix evaluator.
// ---------------------------------------------------------------------------
package pee_pkg;

   localparam int StackDepth = 32;
   localparam int ValueWidth = 32;
   localparam int PtrWidth   = $clog2(StackDepth);
   localparam int CntWidth   = $clog2(StackDepth + 1);
   localparam int QDepth     = 2;

   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [CntWidth-1:0]   count_type;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_POW = 3'd4,
      OP_REM = 3'd5,
      OP_NOP6 = 3'd6,
      OP_NOP7 = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_UNDER = 2'd1,
      ERR_OVER  = 2'd2,
      ERR_DIVZ  = 2'd3
   } err_type;

   // classified token as it sits in the queue
   typedef struct packed {
      logic      is_op;
      op_type    op;
      value_type value;
      logic      last;
   } token_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD2,
      ST_RD1,
      ST_WAIT,
      ST_EXEC,
      ST_DIV,
      ST_POW,
      ST_MUL,
      ST_WRITE,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT
   } state_type;

endpackage

// ===== src/pee_front.sv =====
// ---------------------------------------------------------------------------
// pee_front
// Accepts tokens, classifies them and holds them in a short queue.
// ---------------------------------------------------------------------------
module pee_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [2:0]            req_operator_code,
   input  logic signed [31:0]    req_operand_value,
   input  logic                  req_last_token,
   output logic                  tok_valid,
   output pee_pkg::token_type    tok_data,
   input  logic                  tok_take
);

   pee_pkg::token_type q_ff [pee_pkg::QDepth];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;
   pee_pkg::token_type tok_in;

   assign req_stall = (cnt_ff == 2'(pee_pkg::QDepth));
   assign push      = req_valid && !req_stall;
   assign tok_valid = (cnt_ff != 2'd0);
   assign pop       = tok_valid && tok_take;
   assign tok_data  = q_ff[rd_ff];

   always_comb begin
      tok_in.is_op = req_mode;
      tok_in.op    = pee_pkg::op_type'(req_operator_code);
      tok_in.value = req_operand_value;
      tok_in.last  = req_last_token;
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= tok_in;
      end
   end

endmodule

// ===== src/pee_back.sv =====
// ---------------------------------------------------------------------------
// pee_back
// Executes tokens on the operand stack with a shared iterative unit.
// ---------------------------------------------------------------------------
`include "postfix_expression_evaluator_macros.svh"

module pee_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tok_valid,
   input  pee_pkg::token_type    tok_data,
   output logic                  tok_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_result_value,
   output logic [1:0]            rsp_error_code
);

   localparam int VW = pee_pkg::ValueWidth;
   localparam int SW = $clog2(VW + 1);

   pee_pkg::value_type mem [pee_pkg::StackDepth];
   pee_pkg::value_type rdata_ff;
   logic [pee_pkg::PtrWidth-1:0] raddr;
   logic                         rd_en;
   logic                         wr_en;
   logic [pee_pkg::PtrWidth-1:0] waddr;
   pee_pkg::value_type           wdata;

   pee_pkg::state_type state_ff, state_in;
   pee_pkg::count_type cnt_ff, cnt_in;
   pee_pkg::err_type   err_ff, err_in;
   pee_pkg::token_type tok_ff, tok_in;
   pee_pkg::value_type op1_ff, op1_in, op2_ff, op2_in;
   pee_pkg::value_type acc_ff, acc_in, aux_ff, aux_in, res_ff, res_in;
   pee_pkg::value_type quo_ff, quo_in;
   pee_pkg::value_type rem_ff, rem_in;
   logic [SW-1:0]      step_ff, step_in;
   logic               ov_ff, ov_in;
   pee_pkg::value_type out_val_ff, out_val_in;
   pee_pkg::err_type   out_err_ff, out_err_in;
   logic               pushres;

   logic [VW:0]        rem_sh;
   logic [VW:0]        rem_sub;
   pee_pkg::value_type ma, mb;
   pee_pkg::value_type prod_a, prod_b;
   logic [2*VW-1:0]    prod;

   assign rsp_valid        = ov_ff;
   assign rsp_result_value = out_val_ff;
   assign rsp_error_code   = out_err_ff;

   assign prod = prod_a * prod_b;
   assign ma   = op1_ff[VW-1] ? VW'(-op1_ff) : op1_ff;
   assign mb   = op2_ff[VW-1] ? VW'(-op2_ff) : op2_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      err_in     = err_ff;
      tok_in     = tok_ff;
      op1_in     = op1_ff;
      op2_in     = op2_ff;
      acc_in     = acc_ff;
      aux_in     = aux_ff;
      res_in     = res_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      ov_in      = ov_ff && rsp_stall;
      out_val_in = out_val_ff;
      out_err_in = out_err_ff;
      tok_take   = 1'b0;
      rd_en      = 1'b0;
      raddr      = '0;
      wr_en      = 1'b0;
      waddr      = '0;
      wdata      = res_ff;
      pushres    = 1'b0;
      prod_a     = acc_ff;
      prod_b     = aux_ff;
      rem_sh     = {rem_ff, quo_ff[VW-1]};
      rem_sub    = rem_sh - {1'b0, mb};
      unique case (state_ff)
         pee_pkg::ST_IDLE: begin
            if (tok_valid) begin
               tok_take = 1'b1;
               tok_in   = tok_data;
               if (!tok_data.is_op) begin
                  if (cnt_ff == pee_pkg::count_type'(pee_pkg::StackDepth)) begin
                     if (err_ff == pee_pkg::ERR_OK) err_in = pee_pkg::ERR_OVER;
                  end else begin
                     wr_en  = 1'b1;
                     waddr  = cnt_ff[pee_pkg::PtrWidth-1:0];
                     wdata  = tok_data.value;
                     cnt_in = cnt_ff + 1'b1;
                  end
                  state_in = tok_data.last ? pee_pkg::ST_EMIT_RD : pee_pkg::ST_IDLE;
               end else if (tok_data.op == pee_pkg::OP_NOP6 ||
                            tok_data.op == pee_pkg::OP_NOP7) begin
                  state_in = tok_data.last ? pee_pkg::ST_EMIT_RD : pee_pkg::ST_IDLE;
               end else if (cnt_ff < pee_pkg::count_type'(2)) begin
                  if (err_ff == pee_pkg::ERR_OK) err_in = pee_pkg::ERR_UNDER;
                  state_in = tok_data.last ? pee_pkg::ST_EMIT_RD : pee_pkg::ST_IDLE;
               end else begin
                  state_in = pee_pkg::ST_RD2;
               end
            end
         end
         pee_pkg::ST_RD2: begin
            rd_en    = 1'b1;
            raddr    = pee_pkg::PtrWidth'(cnt_ff - 1'b1);
            state_in = pee_pkg::ST_RD1;
         end
         pee_pkg::ST_RD1: begin
            rd_en    = 1'b1;
            raddr    = pee_pkg::PtrWidth'(cnt_ff - 2'd2);
            op2_in   = rdata_ff;
            state_in = pee_pkg::ST_WAIT;
         end
         pee_pkg::ST_WAIT: begin
            op1_in   = rdata_ff;
            state_in = pee_pkg::ST_EXEC;
         end
         pee_pkg::ST_EXEC: begin
            case (tok_ff.op)
               pee_pkg::OP_ADD: begin
                  res_in = op1_ff + op2_ff;
                  state_in = pee_pkg::ST_WRITE;
               end
               pee_pkg::OP_SUB: begin
                  res_in = op1_ff - op2_ff;
                  state_in = pee_pkg::ST_WRITE;
               end
               pee_pkg::OP_MUL: begin
                  acc_in = op1_ff;
                  aux_in = op2_ff;
                  state_in = pee_pkg::ST_MUL;
               end
               pee_pkg::OP_POW: begin
                  if (op2_ff[VW-1] || op2_ff <= VW'(1)) begin
                     res_in   = op1_ff;
                     state_in = pee_pkg::ST_WRITE;
                  end else begin
                     res_in   = VW'(1);
                     acc_in   = op1_ff;
                     aux_in   = op2_ff;
                     state_in = pee_pkg::ST_POW;
                  end
               end
               default: begin
                  if (op2_ff == '0) begin
                     if (err_ff == pee_pkg::ERR_OK) err_in = pee_pkg::ERR_DIVZ;
                     state_in = tok_ff.last ? pee_pkg::ST_EMIT_RD : pee_pkg::ST_IDLE;
                  end else begin
                     quo_in   = ma;
                     rem_in   = '0;
                     step_in  = SW'(VW);
                     state_in = pee_pkg::ST_DIV;
                  end
               end
            endcase
         end
         pee_pkg::ST_MUL: begin
            res_in   = prod[VW-1:0];
            state_in = pee_pkg::ST_WRITE;
         end
         pee_pkg::ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (step_ff == '0) begin
               if (tok_ff.op == pee_pkg::OP_DIV) begin
                  res_in = (op1_ff[VW-1] != op2_ff[VW-1]) ? VW'(-quo_ff) : quo_ff;
               end else begin
                  res_in = op1_ff[VW-1] ? VW'(-rem_ff) : rem_ff;
               end
               state_in = pee_pkg::ST_WRITE;
            end else begin
               if (!rem_sub[VW]) begin
                  rem_in = rem_sub[VW-1:0];
                  quo_in = {quo_ff[VW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[VW-1:0];
                  quo_in = {quo_ff[VW-2:0], 1'b0};
               end
               step_in = step_ff - 1'b1;
            end
         end
         pee_pkg::ST_POW: begin
            // square-and-multiply; alternate multiply and square on one multiplier
            if (aux_ff == '0) begin
               state_in = pee_pkg::ST_WRITE;
            end else if (step_ff[0] == 1'b0) begin
               prod_a = res_ff;
               prod_b = acc_ff;
               if (aux_ff[0]) res_in = prod[VW-1:0];
               step_in = {step_ff[SW-1:1], 1'b1};
            end else begin
               prod_a = acc_ff;
               prod_b = acc_ff;
               acc_in = prod[VW-1:0];
               aux_in = aux_ff >> 1;
               step_in = {step_ff[SW-1:1], 1'b0};
            end
         end
         pee_pkg::ST_WRITE: begin
            pushres  = 1'b1;
            wr_en    = 1'b1;
            waddr    = pee_pkg::PtrWidth'(cnt_ff - 2'd2);
            wdata    = res_ff;
            cnt_in   = cnt_ff - 1'b1;
            step_in  = '0;
            state_in = tok_ff.last ? pee_pkg::ST_EMIT_RD : pee_pkg::ST_IDLE;
         end
         pee_pkg::ST_EMIT_RD: begin
            rd_en    = 1'b1;
            raddr    = pee_pkg::PtrWidth'(cnt_ff - 1'b1);
            state_in = pee_pkg::ST_EMIT_WAIT;
         end
         pee_pkg::ST_EMIT_WAIT: begin
            state_in = pee_pkg::ST_EMIT;
         end
         pee_pkg::ST_EMIT: begin
            // wait until the output register is free
            if (!ov_ff || !rsp_stall) begin
               ov_in = 1'b1;
               if (cnt_ff == '0) begin
                  out_val_in = '0;
                  out_err_in = (err_ff == pee_pkg::ERR_OK) ? pee_pkg::ERR_UNDER : err_ff;
               end else begin
                  out_val_in = rdata_ff;
                  out_err_in = err_ff;
               end
               cnt_in   = '0;
               err_in   = pee_pkg::ERR_OK;
               state_in = pee_pkg::ST_IDLE;
            end
         end
         default: state_in = pee_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pee_pkg::ST_IDLE;
         cnt_ff   <= '0;
         err_ff   <= pee_pkg::ERR_OK;
         ov_ff    <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
         ov_ff    <= ov_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff     <= tok_in;
      op1_ff     <= op1_in;
      op2_ff     <= op2_in;
      acc_ff     <= acc_in;
      aux_ff     <= aux_in;
      res_ff     <= res_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      out_val_ff <= out_val_in;
      out_err_ff <= out_err_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   `PEE_ASSERT_IMPL(a_cnt_range, clock, reset,
      1'b1, cnt_ff <= pee_pkg::count_type'(pee_pkg::StackDepth), "stack count out of range")
   `PEE_ASSERT_IMPL(a_take_idle, clock, reset,
      tok_take, state_ff == pee_pkg::ST_IDLE, "token taken while busy")
   `PEE_ASSERT_NEXT(a_emit_clears, clock, reset,
      state_ff == pee_pkg::ST_EMIT && state_in == pee_pkg::ST_IDLE,
      cnt_ff == '0 && err_ff == pee_pkg::ERR_OK && ov_ff, "emit did not clear stack")
   `PEE_ASSERT_IMPL(a_write_pops, clock, reset,
      pushres, cnt_ff >= pee_pkg::count_type'(2), "result written with short stack")

endmodule

// ===== src/postfix_expression_evaluator.sv =====
// ---------------------------------------------------------------------------
// postfix_expression_evaluator
// RPN stack calculator with a token queue in front of an execute engine.
// ---------------------------------------------------------------------------
// Usage: tokens enter on req_* (valid/stall); one result leaves on rsp_*
// after each token with req_last_token set, carrying top of stack and the
// sticky error code. The stack and error then clear.
// A two-beat queue takes tokens while the engine works; a token is held in a
// queue register until the engine, back in its idle state, takes it.
// Division and remainder work one quotient bit a cycle over 32 bits; power
// uses square-and-multiply on one shared multiplier, with a multiply step and
// a square step for each exponent bit.
// The operand stack is a 32-entry memory with a registered read port, which
// sets the read states (RD2, RD1, WAIT) before each operator.
// Reset empties queue and stack and drops any result held; no clearing pass.
// While rsp_stall is high the result holds and the engine waits at its next
// emit; tokens keep queueing until the queue fills, then req_stall rises.
// ---------------------------------------------------------------------------
module postfix_expression_evaluator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [2:0]         req_operator_code,
   input  logic signed [31:0] req_operand_value,
   input  logic               req_last_token,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_error_code
);

   logic               tok_valid;
   logic               tok_take;
   pee_pkg::token_type tok_data;

   pee_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_operator_code (req_operator_code),
      .req_operand_value (req_operand_value),
      .req_last_token    (req_last_token),
      .tok_valid         (tok_valid),
      .tok_data          (tok_data),
      .tok_take          (tok_take)
   );

   pee_back u_back (
      .clock            (clock),
      .reset            (reset),
      .tok_valid        (tok_valid),
      .tok_data         (tok_data),
      .tok_take         (tok_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_error_code   (rsp_error_code)
   );

endmodule

// ===== dv/postfix_expression_evaluator_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// postfix_expression_evaluator_checker
// Watches the token and result channels, predicts each result on its own
// copy of the operand stack and compares field by field.
// ---------------------------------------------------------------------------
module postfix_expression_evaluator_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_mode,
   input  logic [2:0]         req_operator_code,
   input  logic signed [31:0] req_operand_value,
   input  logic               req_last_token,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_result_value,
   input  logic [1:0]         rsp_error_code,
   output int                 fail_count,
   output int                 pending_results
);

   typedef struct packed {
      pee_pkg::value_type value;
      pee_pkg::err_type   err;
   } answer_type;

   pee_pkg::value_type calc_stack [pee_pkg::StackDepth];
   int                 calc_depth;
   pee_pkg::err_type   held_err;
   answer_type         answers [$];

   assign pending_results = answers.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, wanted %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic pee_pkg::value_type raise(pee_pkg::value_type base,
                                                pee_pkg::value_type ex);
      pee_pkg::value_type acc;
      pee_pkg::value_type sq;
      if ($signed(ex) <= 1) return base;
      acc = pee_pkg::value_type'(1);
      sq  = base;
      while (ex != 0) begin
         if (ex[0]) acc = acc * sq;
         sq = sq * sq;
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic void note_error(pee_pkg::err_type e);
      if (held_err == pee_pkg::ERR_OK) held_err = e;
   endfunction

   // work one token on the local stack; queue an answer after a last token
   function automatic void evaluate_token(logic mode, pee_pkg::op_type op,
                                          pee_pkg::value_type val, logic last);
      pee_pkg::value_type op1, op2, res, ma, mb, q;
      logic               ok;
      answer_type         ans;
      if (!mode) begin
         if (calc_depth >= pee_pkg::StackDepth) note_error(pee_pkg::ERR_OVER);
         else begin
            calc_stack[calc_depth] = val;
            calc_depth++;
         end
      end else if (op != pee_pkg::OP_NOP6 && op != pee_pkg::OP_NOP7) begin
         if (calc_depth < 2) note_error(pee_pkg::ERR_UNDER);
         else begin
            op2 = calc_stack[calc_depth-1];
            op1 = calc_stack[calc_depth-2];
            ok  = 1'b1;
            res = '0;
            ma  = op1[pee_pkg::ValueWidth-1] ? -op1 : op1;
            mb  = op2[pee_pkg::ValueWidth-1] ? -op2 : op2;
            case (op)
               pee_pkg::OP_ADD: res = op1 + op2;
               pee_pkg::OP_SUB: res = op1 - op2;
               pee_pkg::OP_MUL: res = op1 * op2;
               pee_pkg::OP_POW: res = raise(op1, op2);
               pee_pkg::OP_DIV: begin
                  if (op2 == 0) ok = 1'b0;
                  else begin
                     q   = ma / mb;
                     res = (op1[pee_pkg::ValueWidth-1] != op2[pee_pkg::ValueWidth-1]) ?
                           -q : q;
                  end
               end
               default: begin
                  if (op2 == 0) ok = 1'b0;
                  else begin
                     q   = ma % mb;
                     res = op1[pee_pkg::ValueWidth-1] ? -q : q;
                  end
               end
            endcase
            if (ok) begin
               calc_depth--;
               calc_stack[calc_depth-1] = res;
            end else note_error(pee_pkg::ERR_DIVZ);
         end
      end
      if (last) begin
         if (calc_depth == 0) begin
            note_error(pee_pkg::ERR_UNDER);
            ans.value = '0;
         end else ans.value = calc_stack[calc_depth-1];
         ans.err = held_err;
         answers.push_back(ans);
         calc_depth = 0;
         held_err   = pee_pkg::ERR_OK;
      end
   endfunction

   initial begin
      fail_count = 0;
      calc_depth = 0;
      held_err   = pee_pkg::ERR_OK;
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            evaluate_token(req_mode, pee_pkg::op_type'(req_operator_code),
                           req_operand_value, req_last_token);
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_result_value, '0);
            end else begin
               want = answers.pop_front();
               if (rsp_result_value !== want.value)
                  report_mismatch("result_value", rsp_result_value, want.value);
               if (rsp_error_code !== want.err)
                  report_mismatch("error_code", 32'(rsp_error_code), 32'(want.err));
            end
         end
      end
   end

endmodule

// ===== dv/tb_postfix_expression_evaluator.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Drives directed and random postfix token streams with random idling on
// both channels; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_postfix_expression_evaluator;

   localparam int WatchLimit = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_mode = 1'b0;
   logic [2:0]         req_operator_code = '0;
   logic signed [31:0] req_operand_value = '0;
   logic               req_last_token = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic [1:0]         rsp_error_code;
   int                 fail_count;
   int                 pending_results;
   bit                 calm = 1'b0;
   bit                 hold_off = 1'b0;
   int                 quiet_cycles = 0;
   int                 tokens_sent = 0;

   always #5 clock = ~clock;

   postfix_expression_evaluator u_dut (.*);

   postfix_expression_evaluator_checker u_checker (.*);

   // receiver: random stalls, a long hold when asked
   always @(posedge clock) begin
      int n;
      if (hold_off) begin
         rsp_stall <= 1'b1;
         for (n = 0; n < 300; n++) @(posedge clock);
         hold_off  = 1'b0;
         rsp_stall <= 1'b0;
      end else rsp_stall <= !calm && ($urandom_range(99) < 26);
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("postfix_expression_evaluator verification failed");
         $finish;
      end
   end

   task automatic send(input logic mode, input logic [2:0] op, input logic [31:0] val,
                       input logic last);
      int gap;
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_operator_code <= op;
      req_operand_value <= val;
      req_last_token    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokens_sent++;
      if (!calm && $urandom_range(99) < 26) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic push(input logic [31:0] val, input logic last = 1'b0);
      send(1'b0, 3'($urandom), val, last);
   endtask

   task automatic apply(input pee_pkg::op_type op, input logic last = 1'b0);
      send(1'b1, op, $urandom, last);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return $urandom_range(3) - 1;
         default: return $urandom_range(40) - 20;
      endcase
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      int i, k, n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes and every operation
      push(32'h7fff_ffff); push(32'h0000_0001); apply(pee_pkg::OP_ADD, 1'b1);
      push(32'h8000_0000); push(32'hffff_ffff); apply(pee_pkg::OP_DIV, 1'b1);
      push(32'h8000_0000); push(32'hffff_ffff); apply(pee_pkg::OP_REM, 1'b1);
      push(32'hffff_fff9); push(32'd3); apply(pee_pkg::OP_REM);
      push(32'd5); apply(pee_pkg::OP_SUB); push(32'h1234_5678);
      apply(pee_pkg::OP_MUL, 1'b1);
      push(32'd7); push(32'd0); apply(pee_pkg::OP_DIV); apply(pee_pkg::OP_POW, 1'b1);
      push(32'd3); push(32'hffff_fffe); apply(pee_pkg::OP_POW);
      send(1'b1, pee_pkg::OP_NOP6, '0, 1'b0);
      send(1'b1, pee_pkg::OP_NOP7, '0, 1'b1);
      apply(pee_pkg::OP_ADD, 1'b1);
      send(1'b1, pee_pkg::OP_NOP7, '0, 1'b1);
      push(32'd3); push(32'd13); apply(pee_pkg::OP_POW, 1'b1);

      // random expressions, mostly well formed
      while (tokens_sent < 470) begin
         calm = (tokens_sent > 250 && tokens_sent < 330);
         if (tokens_sent > 120 && tokens_sent < 135 && !hold_off) hold_off = 1'b1;
         if (tokens_sent > 400 && tokens_sent < 410) drain();
         case ($urandom_range(19))
            0: begin
               // overflow the stack
               for (i = 0; i < 34; i++) push($urandom);
               apply(pee_pkg::op_type'($urandom_range(7)), 1'b1);
            end
            1, 2: begin
               n = $urandom_range(1, 4);
               for (i = 0; i < n; i++)
                  send(1'($urandom_range(1)), 3'($urandom_range(7)), pick_value(), 1'b0);
               send(1'($urandom_range(1)), 3'($urandom_range(7)), pick_value(), 1'b1);
            end
            default: begin
               n = $urandom_range(1, 6);
               push(pick_value(), n == 1);
               for (i = 1; i < n; i++) begin
                  push(pick_value());
                  k = $urandom_range(5);
                  apply(pee_pkg::op_type'(k), i == n - 1);
               end
            end
         endcase
      end

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("postfix_expression_evaluator verification clean");
      else $display("postfix_expression_evaluator verification failed");
      $finish;
   end

endmodule
